@@ hw/rtl/hbp_pkg.sv @@
// Package for the hybrid branch predictor: sizes, codes, word types and counter helpers.
`timescale 1ns / 1ps

package hbp_pkg;

  // Largest index widths of the three counter tables.
  localparam int MAX_BIMODAL_BITS = 14;
  localparam int MAX_GSHARE_BITS  = 14;
  localparam int MAX_CHOOSER_BITS = 14;

  // Width of the index-width counts; holds every table width up to 31.
  localparam int CNT_W = 5;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_BIMODAL_IDX = 3'd1;
  localparam logic [2:0] REG_GSHARE_IDX  = 3'd2;
  localparam logic [2:0] REG_HISTORY     = 3'd3;
  localparam logic [2:0] REG_CHOOSER_IDX = 3'd4;

  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  localparam logic [1:0] MODE_RESET        = MODE_HYBRID;
  localparam logic [3:0] BIMODAL_IDX_RESET = 4'd12;
  localparam logic [3:0] GSHARE_IDX_RESET  = 4'd12;
  localparam logic [3:0] HISTORY_RESET     = 4'd8;
  localparam logic [3:0] CHOOSER_IDX_RESET = 4'd10;

  // Table contents after reset.
  localparam logic [1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [1:0] CHOOSER_WEAK_BIM = 2'd1;

  localparam int CTR_W = 2;

  typedef struct packed {
    logic [31:0] branch_pc;
    logic        taken;
  } branch_in_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        mispredicted;
    logic        chose_gshare;
    logic [31:0] mispredict_total;
    logic [31:0] branch_total;
  } branch_out_t;

  // Two-bit saturating counter step.
  function automatic logic [1:0] ctr_train(logic [1:0] ctr, logic up);
    logic [1:0] res;
    res = ctr;
    if (up && ctr != 2'd3) begin
      res = ctr + 2'd1;
    end else if (!up && ctr != 2'd0) begin
      res = ctr - 2'd1;
    end
    return res;
  endfunction

  // Saturating 32-bit increment.
  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ hw/rtl/hbp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module hbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/hybrid_branch_predictor.sv @@
// Hybrid bimodal / gshare branch predictor with a chooser table.
// An accepted word's indices are registered; its result word is registered once the output register is free.
// A new word is taken only after the last one has finished its read and write-back of the counter RAMs.
// Reset: registers and totals clear at once; then a sweep over all 2**max(table index bits)
// addresses (16384 by default) writes the tables to their initial counters while the input is stalled.
// Configuration writes are taken at any time, also during the sweep.
`timescale 1ns / 1ps

module hybrid_branch_predictor #(
  parameter int MAX_BIMODAL_BITS = hbp_pkg::MAX_BIMODAL_BITS,
  parameter int MAX_GSHARE_BITS  = hbp_pkg::MAX_GSHARE_BITS,
  parameter int MAX_CHOOSER_BITS = hbp_pkg::MAX_CHOOSER_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  hbp_pkg::branch_in_t          in_word_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output hbp_pkg::branch_out_t         out_word_o,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hbp_pkg::PADDR_W-1:0]  paddr,
  input  logic [hbp_pkg::PDATA_W-1:0]  pwdata,
  output logic [hbp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int BW = MAX_BIMODAL_BITS;
  localparam int GW = MAX_GSHARE_BITS;
  localparam int CW = MAX_CHOOSER_BITS;
  localparam int BG_W  = (BW > GW) ? BW : GW;
  localparam int CLR_W = (BG_W > CW) ? BG_W : CW;
  localparam int NW = hbp_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // Configuration registers.
  logic [1:0] mode_q;
  logic [3:0] bim_bits_q, gsh_bits_q, hist_bits_q, cho_bits_q;

  state_e              state_q;
  logic [CLR_W-1:0]    clr_cnt_q;
  logic [BW-1:0]       bim_idx_q;
  logic [GW-1:0]       gsh_idx_q;
  logic [CW-1:0]       cho_idx_q;
  logic                taken_q;
  logic [GW-1:0]       history_q, history_d;
  logic [31:0]         br_cnt_q, br_cnt_d, mis_cnt_q, mis_cnt_d;
  logic                out_valid_q;
  hbp_pkg::branch_out_t out_word_q, out_word_d;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hbp_pkg::MODE_RESET;
      bim_bits_q  <= hbp_pkg::BIMODAL_IDX_RESET;
      gsh_bits_q  <= hbp_pkg::GSHARE_IDX_RESET;
      hist_bits_q <= hbp_pkg::HISTORY_RESET;
      cho_bits_q  <= hbp_pkg::CHOOSER_IDX_RESET;
    end else if (cfg_we) begin
      case (paddr[4:2])
        hbp_pkg::REG_MODE:        mode_q      <= pwdata[1:0];
        hbp_pkg::REG_BIMODAL_IDX: bim_bits_q  <= pwdata[3:0];
        hbp_pkg::REG_GSHARE_IDX:  gsh_bits_q  <= pwdata[3:0];
        hbp_pkg::REG_HISTORY:     hist_bits_q <= pwdata[3:0];
        hbp_pkg::REG_CHOOSER_IDX: cho_bits_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      hbp_pkg::REG_MODE:        prdata[1:0] = mode_q;
      hbp_pkg::REG_BIMODAL_IDX: prdata[3:0] = bim_bits_q;
      hbp_pkg::REG_GSHARE_IDX:  prdata[3:0] = gsh_bits_q;
      hbp_pkg::REG_HISTORY:     prdata[3:0] = hist_bits_q;
      hbp_pkg::REG_CHOOSER_IDX: prdata[3:0] = cho_bits_q;
      default:                  prdata      = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Index widths and table indices
  // ---------------------------------------------------------------------------
  function automatic logic [NW-1:0] clamp_bits(logic [3:0] v, int maxb);
    logic [NW-1:0] res;
    res = {{(NW-4){1'b0}}, v};
    if (v == 4'd0) begin
      res = NW'(1);
    end else if (res > NW'(maxb)) begin
      res = NW'(maxb);
    end
    return res;
  endfunction

  logic [NW-1:0] b_w, g_w, c_w, n_w, hist_ext;
  logic [BW-1:0] b_mask;
  logic [GW-1:0] g_mask, n_mask, hist_in, hist_ins;
  logic [CW-1:0] c_mask;
  logic [29:0]   pc_word;
  logic [BW-1:0] bim_idx;
  logic [GW-1:0] gsh_idx;
  logic [CW-1:0] cho_idx;

  assign b_w      = clamp_bits(bim_bits_q, MAX_BIMODAL_BITS);
  assign g_w      = clamp_bits(gsh_bits_q, MAX_GSHARE_BITS);
  assign c_w      = clamp_bits(cho_bits_q, MAX_CHOOSER_BITS);
  assign hist_ext = {{(NW-4){1'b0}}, hist_bits_q};
  assign n_w      = (hist_ext > g_w) ? g_w : hist_ext;

  assign b_mask = ~({BW{1'b1}} << b_w);
  assign g_mask = ~({GW{1'b1}} << g_w);
  assign c_mask = ~({CW{1'b1}} << c_w);
  assign n_mask = ~({GW{1'b1}} << n_w);

  // History as seen under the current length, and placed in the index's top bits.
  assign hist_in = history_q & n_mask;
  assign pc_word = in_word_i.branch_pc[31:2];
  assign bim_idx = pc_word[BW-1:0] & b_mask;
  assign gsh_idx = (pc_word[GW-1:0] ^ (hist_in << (g_w - n_w))) & g_mask;
  assign cho_idx = pc_word[CW-1:0] & c_mask;

  // ---------------------------------------------------------------------------
  // Counter tables
  // ---------------------------------------------------------------------------
  logic           accept, finish, clearing;
  logic [1:0]     bim_ctr, gsh_ctr, cho_ctr;
  logic           bim_we, gsh_we, cho_we;
  logic [1:0]     bim_wdata, gsh_wdata, cho_wdata;
  logic [BW-1:0]  bim_waddr, bim_raddr;
  logic [GW-1:0]  gsh_waddr, gsh_raddr;
  logic [CW-1:0]  cho_waddr, cho_raddr;

  assign clearing   = (state_q == ST_CLEAR);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign finish     = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall_i);

  // While a word waits for the output register, the read addresses hold so the data stays.
  assign bim_raddr = (state_q == ST_UPDATE) ? bim_idx_q : bim_idx;
  assign gsh_raddr = (state_q == ST_UPDATE) ? gsh_idx_q : gsh_idx;
  assign cho_raddr = (state_q == ST_UPDATE) ? cho_idx_q : cho_idx;

  hbp_ram #(.WIDTH(hbp_pkg::CTR_W), .DEPTH(2 ** BW)) u_bim_ram (
    .clk_i   (clk_i),
    .we_i    (bim_we),
    .waddr_i (bim_waddr),
    .wdata_i (bim_wdata),
    .raddr_i (bim_raddr),
    .rdata_o (bim_ctr)
  );

  hbp_ram #(.WIDTH(hbp_pkg::CTR_W), .DEPTH(2 ** GW)) u_gsh_ram (
    .clk_i   (clk_i),
    .we_i    (gsh_we),
    .waddr_i (gsh_waddr),
    .wdata_i (gsh_wdata),
    .raddr_i (gsh_raddr),
    .rdata_o (gsh_ctr)
  );

  hbp_ram #(.WIDTH(hbp_pkg::CTR_W), .DEPTH(2 ** CW)) u_cho_ram (
    .clk_i   (clk_i),
    .we_i    (cho_we),
    .waddr_i (cho_waddr),
    .wdata_i (cho_wdata),
    .raddr_i (cho_raddr),
    .rdata_o (cho_ctr)
  );

  // ---------------------------------------------------------------------------
  // Prediction and training
  // ---------------------------------------------------------------------------
  logic use_gsh, hybrid, pred, miss, bim_ok, gsh_ok;

  assign hybrid = (mode_q != hbp_pkg::MODE_BIMODAL) && (mode_q != hbp_pkg::MODE_GSHARE);

  always_comb begin
    case (mode_q)
      hbp_pkg::MODE_BIMODAL: use_gsh = 1'b0;
      hbp_pkg::MODE_GSHARE:  use_gsh = 1'b1;
      default:               use_gsh = cho_ctr[1];
    endcase
  end

  assign pred   = use_gsh ? gsh_ctr[1] : bim_ctr[1];
  assign miss   = pred != taken_q;
  assign bim_ok = bim_ctr[1] == taken_q;
  assign gsh_ok = gsh_ctr[1] == taken_q;

  // The sweep wraps the smaller tables; it only rewrites the same initial values.
  always_comb begin
    if (clearing) begin
      bim_we    = 1'b1;
      gsh_we    = 1'b1;
      cho_we    = 1'b1;
      bim_waddr = clr_cnt_q[BW-1:0];
      gsh_waddr = clr_cnt_q[GW-1:0];
      cho_waddr = clr_cnt_q[CW-1:0];
      bim_wdata = hbp_pkg::CTR_WEAK_TAKEN;
      gsh_wdata = hbp_pkg::CTR_WEAK_TAKEN;
      cho_wdata = hbp_pkg::CHOOSER_WEAK_BIM;
    end else begin
      bim_we    = finish && !use_gsh;
      gsh_we    = finish && use_gsh;
      cho_we    = finish && hybrid && (bim_ok != gsh_ok);
      bim_waddr = bim_idx_q;
      gsh_waddr = gsh_idx_q;
      cho_waddr = cho_idx_q;
      bim_wdata = hbp_pkg::ctr_train(bim_ctr, taken_q);
      gsh_wdata = hbp_pkg::ctr_train(gsh_ctr, taken_q);
      cho_wdata = hbp_pkg::ctr_train(cho_ctr, gsh_ok);
    end
  end

  // History shifts right with the outcome entering at the top of its current length.
  assign hist_ins  = (taken_q && n_w != '0) ? (GW'(1) << (n_w - NW'(1))) : '0;
  assign history_d = (mode_q == hbp_pkg::MODE_BIMODAL) ? history_q
                                                       : (((hist_in >> 1) | hist_ins) & n_mask);

  assign br_cnt_d  = hbp_pkg::sat_inc(br_cnt_q);
  assign mis_cnt_d = miss ? hbp_pkg::sat_inc(mis_cnt_q) : mis_cnt_q;

  always_comb begin
    out_word_d.predicted_taken  = pred;
    out_word_d.mispredicted     = miss;
    out_word_d.chose_gshare     = use_gsh;
    out_word_d.mispredict_total = mis_cnt_d;
    out_word_d.branch_total     = br_cnt_d;
  end

  // ---------------------------------------------------------------------------
  // Sequencer, history, totals and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      bim_idx_q   <= '0;
      gsh_idx_q   <= '0;
      cho_idx_q   <= '0;
      taken_q     <= 1'b0;
      history_q   <= '0;
      br_cnt_q    <= '0;
      mis_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // A finishing word refills the output register in the cycle the old one leaves.
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + CLR_W'(1);
          if (clr_cnt_q == {CLR_W{1'b1}}) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            bim_idx_q <= bim_idx;
            gsh_idx_q <= gsh_idx;
            cho_idx_q <= cho_idx;
            taken_q   <= in_word_i.taken;
            state_q   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (finish) begin
            history_q   <= history_d;
            br_cnt_q    <= br_cnt_d;
            mis_cnt_q   <= mis_cnt_d;
            out_word_q  <= out_word_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_then_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_UPDATE))
    else $error("accepted word did not move to the update cycle");

  a_finish_gives_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o)
    else $error("finished update produced no result word");

  a_one_table_trained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing |-> !(bim_we && gsh_we))
    else $error("both prediction tables written for one branch");

  a_misses_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mis_cnt_q <= br_cnt_q)
    else $error("mispredict total exceeds branch total");

  a_total_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    br_cnt_q >= $past(br_cnt_q))
    else $error("branch total went down");

endmodule

@@ bench/hybrid_branch_predictor_tb.sv @@
// Self-checking testbench for the hybrid branch predictor: directed and random branches.
`timescale 1ns / 1ps

module hybrid_branch_predictor_tb;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned POOL_SIZE = 16;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 95;
  // The spare mode code behaves as hybrid.
  localparam logic [1:0] MODE_HYBRID_TOO = 2'd3;

  localparam int PADDR_W = hbp_pkg::PADDR_W;
  localparam int PDATA_W = hbp_pkg::PDATA_W;

  localparam int unsigned BIM_DEPTH = 1 << hbp_pkg::MAX_BIMODAL_BITS;
  localparam int unsigned GSH_DEPTH = 1 << hbp_pkg::MAX_GSHARE_BITS;
  localparam int unsigned SEL_DEPTH = 1 << hbp_pkg::MAX_CHOOSER_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  hbp_pkg::branch_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  hbp_pkg::branch_out_t out_word_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  hybrid_branch_predictor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state and register copies.
  logic [1:0] bim_ctr [BIM_DEPTH];
  logic [1:0] gsh_ctr [GSH_DEPTH];
  logic [1:0] sel_ctr [SEL_DEPTH];
  int unsigned ghist = 0;
  logic [31:0] miss_total = '0;
  logic [31:0] seen_total = '0;
  logic [1:0] cfg_mode = hbp_pkg::MODE_RESET;
  logic [3:0] cfg_bim_bits = hbp_pkg::BIMODAL_IDX_RESET;
  logic [3:0] cfg_gsh_bits = hbp_pkg::GSHARE_IDX_RESET;
  logic [3:0] cfg_hist_bits = hbp_pkg::HISTORY_RESET;
  logic [3:0] cfg_sel_bits = hbp_pkg::CHOOSER_IDX_RESET;

  hbp_pkg::branch_out_t predicted_outcomes [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  // Branch address pool with a behaviour per entry, refreshed for each phase.
  logic [31:0] pool_pc [POOL_SIZE];
  int unsigned pool_kind [POOL_SIZE];
  int unsigned pool_period [POOL_SIZE];
  int unsigned pool_trip [POOL_SIZE];

  initial begin
    for (int i = 0; i < BIM_DEPTH; i++) bim_ctr[i] = hbp_pkg::CTR_WEAK_TAKEN;
    for (int i = 0; i < GSH_DEPTH; i++) gsh_ctr[i] = hbp_pkg::CTR_WEAK_TAKEN;
    for (int i = 0; i < SEL_DEPTH; i++) sel_ctr[i] = hbp_pkg::CHOOSER_WEAK_BIM;
  end

  function automatic int unsigned width_mask(int unsigned bits);
    return (1 << bits) - 1;
  endfunction

  function automatic int unsigned clamp_width(logic [3:0] v, int unsigned top);
    if (v == 4'd0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [1:0] bump_ctr(logic [1:0] ctr, logic up);
    if (up) return (ctr == 2'd3) ? ctr : ctr + 2'd1;
    return (ctr == 2'd0) ? ctr : ctr - 2'd1;
  endfunction

  // Predicts one branch and trains the predictor state as the block does.
  function automatic hbp_pkg::branch_out_t predict_branch(hbp_pkg::branch_in_t w);
    int unsigned word, b, g, c, n, hist, bi, gi, ci, ins;
    logic t, bim_p, gsh_p, pick_g, pred;
    hbp_pkg::branch_out_t r;
    word = w.branch_pc >> 2;
    t = w.taken;
    b = clamp_width(cfg_bim_bits, hbp_pkg::MAX_BIMODAL_BITS);
    g = clamp_width(cfg_gsh_bits, hbp_pkg::MAX_GSHARE_BITS);
    c = clamp_width(cfg_sel_bits, hbp_pkg::MAX_CHOOSER_BITS);
    n = (cfg_hist_bits > g) ? g : cfg_hist_bits;
    hist = ghist & width_mask(n);
    bi = word & width_mask(b);
    gi = ((word & width_mask(g)) ^ (hist << (g - n))) & width_mask(g);
    ci = word & width_mask(c);
    bim_p = bim_ctr[bi] >= 2'd2;
    gsh_p = gsh_ctr[gi] >= 2'd2;
    if (cfg_mode == hbp_pkg::MODE_BIMODAL) pick_g = 1'b0;
    else if (cfg_mode == hbp_pkg::MODE_GSHARE) pick_g = 1'b1;
    else pick_g = sel_ctr[ci] >= 2'd2;
    pred = pick_g ? gsh_p : bim_p;

    if (pick_g) gsh_ctr[gi] = bump_ctr(gsh_ctr[gi], t);
    else bim_ctr[bi] = bump_ctr(bim_ctr[bi], t);

    if (cfg_mode != hbp_pkg::MODE_BIMODAL) begin
      ins = (t && n > 0) ? (1 << (n - 1)) : 0;
      ghist = ((hist >> 1) | ins) & width_mask(n);
    end

    // The chooser only moves when exactly one of the two tables was right.
    if (cfg_mode == hbp_pkg::MODE_HYBRID || cfg_mode == MODE_HYBRID_TOO) begin
      if (gsh_p == t && bim_p != t) sel_ctr[ci] = bump_ctr(sel_ctr[ci], 1'b1);
      else if (bim_p == t && gsh_p != t) sel_ctr[ci] = bump_ctr(sel_ctr[ci], 1'b0);
    end

    if (seen_total != 32'hFFFF_FFFF) seen_total = seen_total + 32'd1;
    if (pred != t && miss_total != 32'hFFFF_FFFF) miss_total = miss_total + 32'd1;

    r.predicted_taken = pred;
    r.mispredicted = pred != t;
    r.chose_gshare = pick_g;
    r.mispredict_total = miss_total;
    r.branch_total = seen_total;
    return r;
  endfunction

  // Offers one branch word, sometimes after a random idle gap, and holds it until the block takes it.
  task automatic send_branch(logic [31:0] pc, logic t);
    hbp_pkg::branch_in_t w;
    w.branch_pc = pc;
    w.taken = t;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted_outcomes.push_back(predict_branch(w));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Writes a register once the block is idle, then reads it back.
  task automatic set_reg(logic [2:0] idx, logic [3:0] val);
    logic [PDATA_W-1:0] want;
    want = (idx == hbp_pkg::REG_MODE) ? PDATA_W'(val[1:0]) : PDATA_W'(val);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      hbp_pkg::REG_MODE:        cfg_mode = val[1:0];
      hbp_pkg::REG_BIMODAL_IDX: cfg_bim_bits = val;
      hbp_pkg::REG_GSHARE_IDX:  cfg_gsh_bits = val;
      hbp_pkg::REG_HISTORY:     cfg_hist_bits = val;
      hbp_pkg::REG_CHOOSER_IDX: cfg_sel_bits = val;
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("register %0d read back %h, expected %h", idx, prdata, want);
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [3:0] pick_width();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return 4'd0;
        1: return 4'd1;
        2: return 4'd14;
        default: return 4'd15;
      endcase
    end
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic refill_pool();
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_pc[k] = $urandom;
      // Some pairs differ in one address bit from bit 8 up, so they alias in tables whose index misses that bit.
      if (k % 2 == 1 && $urandom_range(0, 1) == 1)
        pool_pc[k] = pool_pc[k - 1] ^ (32'h1 << $urandom_range(8, 31));
      pool_kind[k] = $urandom_range(0, 3);
      pool_period[k] = $urandom_range(2, 6);
      pool_trip[k] = 0;
    end
  endtask

  // Mostly loop-like and biased branches from the pool, some fully random ones.
  task automatic send_pool_branch();
    int unsigned k;
    logic t;
    if ($urandom_range(0, 6) == 0) begin
      send_branch($urandom, 1'($urandom_range(0, 1)));
    end else begin
      k = $urandom_range(0, POOL_SIZE - 1);
      case (pool_kind[k])
        0: t = $urandom_range(0, 9) != 0;
        1: t = $urandom_range(0, 9) == 0;
        2: begin
          t = (pool_trip[k] % pool_period[k]) != pool_period[k] - 1;
          pool_trip[k]++;
        end
        default: t = 1'($urandom_range(0, 1));
      endcase
      send_branch(pool_pc[k], t);
    end
  endtask

  task automatic test_directed();
    // Reset settings: hybrid, with address extremes.
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_1000, 1'b1);
    send_branch(32'h0000_1000, 1'b0);
    // Bimodal with a zero index width, which is taken as one bit.
    set_reg(hbp_pkg::REG_MODE, 4'(hbp_pkg::MODE_BIMODAL));
    set_reg(hbp_pkg::REG_BIMODAL_IDX, 4'd0);
    send_branch(32'h0000_0004, 1'b0);
    send_branch(32'h0000_0004, 1'b0);
    send_branch(32'hFFFF_FFFC, 1'b1);
    // Gshare with an oversized index and a history longer than the index.
    set_reg(hbp_pkg::REG_MODE, 4'(hbp_pkg::MODE_GSHARE));
    set_reg(hbp_pkg::REG_GSHARE_IDX, 4'd15);
    set_reg(hbp_pkg::REG_HISTORY, 4'd15);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_8000, 1'b0);
    // No history at all.
    set_reg(hbp_pkg::REG_HISTORY, 4'd0);
    send_branch(32'h0000_0010, 1'b1);
    send_branch(32'h0000_0010, 1'b0);
    // Spare mode code with chooser widths at both ends.
    set_reg(hbp_pkg::REG_MODE, 4'(MODE_HYBRID_TOO));
    set_reg(hbp_pkg::REG_CHOOSER_IDX, 4'd0);
    set_reg(hbp_pkg::REG_HISTORY, 4'd4);
    send_branch(32'h0000_0020, 1'b1);
    send_branch(32'h0000_0020, 1'b0);
    send_branch(32'h0000_0024, 1'b1);
    set_reg(hbp_pkg::REG_CHOOSER_IDX, 4'd15);
    send_branch(32'h0000_0020, 1'b0);
    // Bimodal leaves the history alone; gshare then picks it up again.
    set_reg(hbp_pkg::REG_MODE, 4'(hbp_pkg::MODE_BIMODAL));
    send_branch(32'h0000_0040, 1'b1);
    set_reg(hbp_pkg::REG_MODE, 4'(hbp_pkg::MODE_GSHARE));
    send_branch(32'h0000_0040, 1'b1);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_reg(hbp_pkg::REG_MODE, 4'(p % 4));
      set_reg(hbp_pkg::REG_BIMODAL_IDX, pick_width());
      set_reg(hbp_pkg::REG_GSHARE_IDX, pick_width());
      set_reg(hbp_pkg::REG_HISTORY, pick_width());
      set_reg(hbp_pkg::REG_CHOOSER_IDX, pick_width());
      refill_pool();
      repeat (PHASE_ITEMS) send_pool_branch();
    end
  endtask

  task automatic test_backpressure();
    set_reg(hbp_pkg::REG_MODE, 4'(hbp_pkg::MODE_HYBRID));
    set_reg(hbp_pkg::REG_HISTORY, 4'd14);
    refill_pool();
    hold_req = 1'b1;
    repeat (60) send_pool_branch();
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    set_reg(hbp_pkg::REG_BIMODAL_IDX, 4'd12);
    set_reg(hbp_pkg::REG_GSHARE_IDX, 4'd12);
    set_reg(hbp_pkg::REG_HISTORY, 4'd8);
    set_reg(hbp_pkg::REG_CHOOSER_IDX, 4'd10);
    refill_pool();
    repeat (90) send_pool_branch();
  endtask

  // Receiver stalls: random bursts, and one long hold when asked for.
  initial begin : rx_stall_gen
    int unsigned len;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        len = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each accepted result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    hbp_pkg::branch_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result word with nothing expected: %p", out_word_o);
      end else begin
        want = predicted_outcomes.pop_front();
        if (out_word_o.predicted_taken !== want.predicted_taken ||
            out_word_o.mispredicted !== want.mispredicted ||
            out_word_o.chose_gshare !== want.chose_gshare ||
            out_word_o.mispredict_total !== want.mispredict_total ||
            out_word_o.branch_total !== want.branch_total) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected pred %0b miss %0b gsh %0b mtot %0d btot %0d,",
                      " got pred %0b miss %0b gsh %0b mtot %0d btot %0d"},
                     want.predicted_taken, want.mispredicted, want.chose_gshare,
                     want.mispredict_total, want.branch_total,
                     out_word_o.predicted_taken, out_word_o.mispredicted,
                     out_word_o.chose_gshare, out_word_o.mispredict_total,
                     out_word_o.branch_total);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
